// ----- src/pirc_pkg.sv -----
package pirc_pkg;

    localparam int MEAS_WIDTH_DEF = 16;

    localparam int CFG_W   = 16;
    localparam int ISP_W   = 32;
    localparam int TICK_W  = 16;
    localparam int ERR_W   = 17;
    localparam int INTEG_W = 48;
    localparam int DRIVE_W = 32;
    localparam int ACC_W   = 50;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PSHIFT  = 8;
    localparam int PTERM_W = ERR_W + CFG_W - PSHIFT;

    localparam int ERR_MAX = 65535;

    localparam int DIV_STEPS = INTEG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P_GAIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ISP      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_I_MIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_I_MAX    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INCR     = 3'd5;

    localparam logic signed [CFG_W-1:0] SETPOINT_RST = 16'sd0;
    localparam logic signed [CFG_W-1:0] P_GAIN_RST   = 16'sd256;
    localparam logic [ISP_W-1:0]        ISP_RST      = 32'd1000;
    localparam logic signed [CFG_W-1:0] I_MIN_RST    = -16'sd100;
    localparam logic signed [CFG_W-1:0] I_MAX_RST    = 16'sd100;
    localparam logic                    INCR_RST     = 1'b1;

    localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] DRIVE_MIN = -DRIVE_MAX - ACC_W'(1);

    localparam int STEP_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ERR,
        OP_MUL_TE,
        OP_ADD_SUM,
        OP_MUL_LO,
        OP_CLAMP_LO,
        OP_MUL_HI,
        OP_CLAMP_HI,
        OP_MUL_P,
        OP_PTERM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ITERM,
        OP_ADD_DRIVE,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_IN,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jcond_t;

    typedef struct packed {
        op_t               op;
        jcond_t            jc;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic in_req;
        logic div_more;
        logic out_busy;
    } seq_stat_t;

    localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIV   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DRIVE = 4'd13;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, jc: JC_ALWAYS, target: STEP_WAIT};
        case (addr)
            4'd0:  w = '{op: OP_WAIT,      jc: JC_NO_IN,    target: STEP_WAIT};
            4'd1:  w = '{op: OP_ERR,       jc: JC_NEXT,     target: STEP_WAIT};
            4'd2:  w = '{op: OP_MUL_TE,    jc: JC_NEXT,     target: STEP_WAIT};
            4'd3:  w = '{op: OP_ADD_SUM,   jc: JC_NEXT,     target: STEP_WAIT};
            4'd4:  w = '{op: OP_MUL_LO,    jc: JC_NEXT,     target: STEP_WAIT};
            4'd5:  w = '{op: OP_CLAMP_LO,  jc: JC_NEXT,     target: STEP_WAIT};
            4'd6:  w = '{op: OP_MUL_HI,    jc: JC_NEXT,     target: STEP_WAIT};
            4'd7:  w = '{op: OP_CLAMP_HI,  jc: JC_NEXT,     target: STEP_WAIT};
            4'd8:  w = '{op: OP_MUL_P,     jc: JC_NEXT,     target: STEP_WAIT};
            4'd9:  w = '{op: OP_PTERM,     jc: JC_NEXT,     target: STEP_WAIT};
            4'd10: w = '{op: OP_DIV_INIT,  jc: JC_NEXT,     target: STEP_WAIT};
            4'd11: w = '{op: OP_DIV_STEP,  jc: JC_DIV_MORE, target: STEP_DIV};
            4'd12: w = '{op: OP_ITERM,     jc: JC_NEXT,     target: STEP_WAIT};
            4'd13: w = '{op: OP_ADD_DRIVE, jc: JC_OUT_BUSY, target: STEP_DRIVE};
            4'd14: w = '{op: OP_OUT,       jc: JC_ALWAYS,   target: STEP_WAIT};
            default: w = '{op: OP_NOP,     jc: JC_ALWAYS,   target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/pirc_seq.sv -----
module pirc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  pirc_pkg::seq_stat_t stat,
    output pirc_pkg::op_t       op
);

    logic [pirc_pkg::STEP_W-1:0] step_reg;
    logic [pirc_pkg::STEP_W-1:0] step_next;
    pirc_pkg::ucode_t            word;
    logic                        take;

    always_comb begin
        word = pirc_pkg::ucode_rom(step_reg);
    end

    always_comb begin
        case (word.jc)
            pirc_pkg::JC_NEXT:     take = 1'b0;
            pirc_pkg::JC_ALWAYS:   take = 1'b1;
            pirc_pkg::JC_NO_IN:    take = !stat.in_req;
            pirc_pkg::JC_DIV_MORE: take = stat.div_more;
            pirc_pkg::JC_OUT_BUSY: take = stat.out_busy;
            default:               take = 1'b1;
        endcase
    end

    always_comb begin
        step_next = take ? word.target : step_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pirc_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    assign op = word.op;

endmodule

// ----- src/pi_regulator_clamped_integral.sv -----
// PI regulator with a clamped integrator.
// Input requests (s_valid/s_ready) carry a signed measurement and the ticks
// elapsed since the previous one. Each request yields exactly one result
// request (m_valid/m_ready) with the error, the new clamped error integral
// and the saturated actuator drive.
// Registers are written over the APB port at byte address 4*i: setpoint,
// p_gain, i_sum_per_unit, i_min, i_max and actuator_increments. Writes are
// expected only while the block is idle.
// A microcoded sequencer steps one shared 33x17 multiplier, an adder and a
// restoring divider through the work. The divider takes one quotient bit per
// cycle for the 48-bit quotient, and a new request is taken only once the
// result of the last one has been loaded into the result register.
// The result sits in an output register, so the next request is taken and
// worked on while it waits; a stalled receiver holds the sequencer only just
// before the result register is loaded.
// Reset restores the register defaults and clears the error integral.
module pi_regulator_clamped_integral #(
    parameter int MEAS_WIDTH = pirc_pkg::MEAS_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [MEAS_WIDTH-1:0]          s_measurement,
    input  logic [pirc_pkg::TICK_W-1:0]           s_elapsed_ticks,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pirc_pkg::ERR_W-1:0]     m_error_value,
    output logic signed [pirc_pkg::INTEG_W-1:0]   m_integral_value,
    output logic signed [pirc_pkg::DRIVE_W-1:0]   m_actuator_drive,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pirc_pkg::ADDR_W-1:0]           paddr,
    input  logic [pirc_pkg::DATA_W-1:0]           pwdata,
    output logic [pirc_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int DIFF_W = ((MEAS_WIDTH > pirc_pkg::CFG_W) ? MEAS_WIDTH : pirc_pkg::CFG_W) + 1;
    localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(pirc_pkg::ERR_MAX);
    localparam logic signed [DIFF_W-1:0] DIFF_LO = -DIFF_HI - DIFF_W'(1);

    localparam int ERR_W   = pirc_pkg::ERR_W;
    localparam int ACC_W   = pirc_pkg::ACC_W;
    localparam int INTEG_W = pirc_pkg::INTEG_W;
    localparam int ISP_W   = pirc_pkg::ISP_W;
    localparam int CFG_W   = pirc_pkg::CFG_W;
    localparam int PTERM_W = pirc_pkg::PTERM_W;
    localparam int MUL_A_W = pirc_pkg::MUL_A_W;
    localparam int MUL_B_W = pirc_pkg::MUL_B_W;
    localparam int CNT_W   = pirc_pkg::DIV_CNT_W;

    // Configuration registers.
    logic signed [CFG_W-1:0] setpoint_reg;
    logic signed [CFG_W-1:0] p_gain_reg;
    logic [ISP_W-1:0]        isp_reg;
    logic signed [CFG_W-1:0] i_min_reg;
    logic signed [CFG_W-1:0] i_max_reg;
    logic                    incr_reg;

    logic                                 cfg_wr;
    logic [pirc_pkg::REG_IDX_W-1:0]       cfg_idx;

    // Datapath registers.
    logic signed [MEAS_WIDTH-1:0]       meas_reg;
    logic [pirc_pkg::TICK_W-1:0]        ticks_reg;
    logic signed [ERR_W-1:0]            err_reg, err_next;
    logic signed [ACC_W-1:0]            acc_reg, acc_next;
    logic signed [ACC_W-1:0]            prod_reg, prod_next;
    logic signed [INTEG_W-1:0]          integral_reg, integral_next;
    logic signed [PTERM_W-1:0]          pterm_reg, pterm_next;
    logic [INTEG_W-1:0]                 quot_reg, quot_next;
    logic [ISP_W-1:0]                   rem_reg, rem_next;
    logic [CNT_W-1:0]                   div_cnt_reg, div_cnt_next;
    logic                               neg_reg, neg_next;

    logic                               m_valid_reg, m_valid_next;
    logic signed [ERR_W-1:0]            m_error_value_reg;
    logic signed [INTEG_W-1:0]          m_integral_value_reg;
    logic signed [pirc_pkg::DRIVE_W-1:0] m_actuator_drive_reg;

    pirc_pkg::op_t       op;
    pirc_pkg::seq_stat_t stat;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]   acc_mag;
    logic signed [ACC_W-1:0]   quot_ext;
    logic signed [ACC_W-1:0]   drive_full;
    logic signed [pirc_pkg::DRIVE_W-1:0] drive_sat;
    logic [ISP_W:0]            rem_sh;
    logic [ISP_W+1:0]          div_trial;
    logic                      div_ge;

    pirc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .op      (op)
    );

    assign s_ready = (op == pirc_pkg::OP_WAIT);

    always_comb begin
        stat.in_req   = s_valid;
        stat.div_more = (div_cnt_reg != '0);
        stat.out_busy = m_valid_reg && !m_ready;
    end

    // APB register file.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[pirc_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= pirc_pkg::SETPOINT_RST;
            p_gain_reg   <= pirc_pkg::P_GAIN_RST;
            isp_reg      <= pirc_pkg::ISP_RST;
            i_min_reg    <= pirc_pkg::I_MIN_RST;
            i_max_reg    <= pirc_pkg::I_MAX_RST;
            incr_reg     <= pirc_pkg::INCR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pirc_pkg::REG_SETPOINT: setpoint_reg <= pwdata[CFG_W-1:0];
                pirc_pkg::REG_P_GAIN:   p_gain_reg   <= pwdata[CFG_W-1:0];
                pirc_pkg::REG_ISP:      isp_reg      <= pwdata[ISP_W-1:0];
                pirc_pkg::REG_I_MIN:    i_min_reg    <= pwdata[CFG_W-1:0];
                pirc_pkg::REG_I_MAX:    i_max_reg    <= pwdata[CFG_W-1:0];
                pirc_pkg::REG_INCR:     incr_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            pirc_pkg::REG_SETPOINT: prdata = {{(pirc_pkg::DATA_W-CFG_W){setpoint_reg[CFG_W-1]}},
                                              setpoint_reg};
            pirc_pkg::REG_P_GAIN:   prdata = {{(pirc_pkg::DATA_W-CFG_W){p_gain_reg[CFG_W-1]}},
                                              p_gain_reg};
            pirc_pkg::REG_ISP:      prdata = isp_reg;
            pirc_pkg::REG_I_MIN:    prdata = {{(pirc_pkg::DATA_W-CFG_W){i_min_reg[CFG_W-1]}},
                                              i_min_reg};
            pirc_pkg::REG_I_MAX:    prdata = {{(pirc_pkg::DATA_W-CFG_W){i_max_reg[CFG_W-1]}},
                                              i_max_reg};
            pirc_pkg::REG_INCR:     prdata = {{(pirc_pkg::DATA_W-1){1'b0}}, incr_reg};
            default:                prdata = '0;
        endcase
    end

    // Shared arithmetic.
    always_comb begin
        diff = {{(DIFF_W-MEAS_WIDTH){meas_reg[MEAS_WIDTH-1]}}, meas_reg}
             - {{(DIFF_W-CFG_W){setpoint_reg[CFG_W-1]}}, setpoint_reg};
    end

    always_comb begin
        case (op)
            pirc_pkg::OP_MUL_TE: begin
                mul_a = {{(MUL_A_W-pirc_pkg::TICK_W){1'b0}}, ticks_reg};
                mul_b = err_reg;
            end
            pirc_pkg::OP_MUL_LO: begin
                mul_a = {1'b0, isp_reg};
                mul_b = {i_min_reg[CFG_W-1], i_min_reg};
            end
            pirc_pkg::OP_MUL_HI: begin
                mul_a = {1'b0, isp_reg};
                mul_b = {i_max_reg[CFG_W-1], i_max_reg};
            end
            pirc_pkg::OP_MUL_P: begin
                mul_a = {{(MUL_A_W-CFG_W){p_gain_reg[CFG_W-1]}}, p_gain_reg};
                mul_b = err_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign acc_mag  = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign quot_ext = {{(ACC_W-INTEG_W){1'b0}}, quot_reg};
    assign rem_sh   = {rem_reg, quot_reg[INTEG_W-1]};
    assign div_trial = {1'b0, rem_sh} - {2'b00, isp_reg};
    assign div_ge    = !div_trial[ISP_W+1];

    assign drive_full = incr_reg ? -prod_reg : prod_reg;

    always_comb begin
        if (drive_full > pirc_pkg::DRIVE_MAX) begin
            drive_sat = pirc_pkg::DRIVE_MAX[pirc_pkg::DRIVE_W-1:0];
        end else if (drive_full < pirc_pkg::DRIVE_MIN) begin
            drive_sat = pirc_pkg::DRIVE_MIN[pirc_pkg::DRIVE_W-1:0];
        end else begin
            drive_sat = drive_full[pirc_pkg::DRIVE_W-1:0];
        end
    end

    always_comb begin
        err_next      = err_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        integral_next = integral_reg;
        pterm_next    = pterm_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        neg_next      = neg_reg;
        case (op)
            pirc_pkg::OP_ERR: begin
                if (diff > DIFF_HI) begin
                    err_next = DIFF_HI[ERR_W-1:0];
                end else if (diff < DIFF_LO) begin
                    err_next = DIFF_LO[ERR_W-1:0];
                end else begin
                    err_next = diff[ERR_W-1:0];
                end
            end
            pirc_pkg::OP_MUL_TE, pirc_pkg::OP_MUL_LO,
            pirc_pkg::OP_MUL_HI, pirc_pkg::OP_MUL_P: begin
                prod_next = mul_p;
            end
            pirc_pkg::OP_ADD_SUM: begin
                acc_next = {{(ACC_W-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg} + prod_reg;
            end
            pirc_pkg::OP_CLAMP_LO: begin
                if (acc_reg < prod_reg) begin
                    acc_next = prod_reg;
                end
            end
            pirc_pkg::OP_CLAMP_HI: begin
                // The result is the sum, the lower limit or the upper limit,
                // each of which fits the 48-bit integral.
                if (acc_reg > prod_reg) begin
                    acc_next      = prod_reg;
                    integral_next = prod_reg[INTEG_W-1:0];
                end else begin
                    integral_next = acc_reg[INTEG_W-1:0];
                end
            end
            pirc_pkg::OP_PTERM: begin
                pterm_next = prod_reg[pirc_pkg::PSHIFT+PTERM_W-1:pirc_pkg::PSHIFT];
            end
            pirc_pkg::OP_DIV_INIT: begin
                neg_next     = acc_reg[ACC_W-1];
                quot_next    = acc_mag[INTEG_W-1:0];
                rem_next     = '0;
                div_cnt_next = CNT_W'(pirc_pkg::DIV_STEPS - 1);
            end
            pirc_pkg::OP_DIV_STEP: begin
                quot_next    = {quot_reg[INTEG_W-2:0], div_ge};
                rem_next     = div_ge ? div_trial[ISP_W-1:0] : rem_sh[ISP_W-1:0];
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            pirc_pkg::OP_ITERM: begin
                if (isp_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = neg_reg ? -quot_ext : quot_ext;
                end
            end
            pirc_pkg::OP_ADD_DRIVE: begin
                prod_next = acc_reg + {{(ACC_W-PTERM_W){pterm_reg[PTERM_W-1]}}, pterm_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        if (op == pirc_pkg::OP_OUT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            integral_reg <= integral_next;
            div_cnt_reg  <= div_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            meas_reg  <= s_measurement;
            ticks_reg <= s_elapsed_ticks;
        end
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        pterm_reg <= pterm_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        if (op == pirc_pkg::OP_OUT) begin
            m_error_value_reg    <= err_reg;
            m_integral_value_reg <= integral_reg;
            m_actuator_drive_reg <= drive_sat;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_error_value    = m_error_value_reg;
    assign m_integral_value = m_integral_value_reg;
    assign m_actuator_drive = m_actuator_drive_reg;

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> op == pirc_pkg::OP_ERR)
        else $error("accepted request did not start the program");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(op == pirc_pkg::OP_OUT))
        else $error("result raised outside the output step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> op != pirc_pkg::OP_OUT)
        else $error("pending result would be overwritten");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        op == pirc_pkg::OP_DIV_STEP && div_cnt_reg == '0 |=> op == pirc_pkg::OP_ITERM)
        else $error("divider loop did not end after its last step");

endmodule

// ----- tb/sv/pi_regulator_clamped_integral_tb.sv -----
`timescale 1ns / 100ps

module pi_regulator_clamped_integral_tb;

    localparam int MEAS_W = pirc_pkg::MEAS_WIDTH_DEF;
    localparam int REG_IDX_W = pirc_pkg::REG_IDX_W;
    localparam int ADDR_W = pirc_pkg::ADDR_W;
    localparam int DATA_W = pirc_pkg::DATA_W;
    localparam int CFG_W = pirc_pkg::CFG_W;
    localparam int ISP_W = pirc_pkg::ISP_W;
    localparam int TICK_W = pirc_pkg::TICK_W;
    localparam int ERR_W = pirc_pkg::ERR_W;
    localparam int INTEG_W = pirc_pkg::INTEG_W;
    localparam int DRIVE_W = pirc_pkg::DRIVE_W;
    localparam int PSHIFT = pirc_pkg::PSHIFT;
    localparam int ERR_MAX = pirc_pkg::ERR_MAX;
    localparam int PLAN_ROWS = 28;
    localparam int RANDOM_PHASES = 7;
    localparam int SAMPLES_PER_PHASE = 100;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint INTEG_TOP = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;

    typedef struct packed {
        logic signed [ERR_W-1:0]   error_value;
        logic signed [INTEG_W-1:0] integral;
        logic signed [DRIVE_W-1:0] drive;
    } loop_result_t;

    typedef struct {
        bit                       is_write;
        logic [REG_IDX_W-1:0]     reg_idx;
        logic [DATA_W-1:0]        reg_val;
        logic signed [MEAS_W-1:0] meas;
        logic [TICK_W-1:0]        ticks;
        bit                       typed;
        loop_result_t             known;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [MEAS_W-1:0]  s_measurement = '0;
    logic [TICK_W-1:0]         s_elapsed_ticks = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b1;
    logic signed [ERR_W-1:0]   m_error_value;
    logic signed [INTEG_W-1:0] m_integral_value;
    logic signed [DRIVE_W-1:0] m_actuator_drive;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    logic signed [CFG_W-1:0]   setpoint_cfg = pirc_pkg::SETPOINT_RST;
    logic signed [CFG_W-1:0]   kp_cfg = pirc_pkg::P_GAIN_RST;
    logic [ISP_W-1:0]          isp_cfg = pirc_pkg::ISP_RST;
    logic signed [CFG_W-1:0]   imin_cfg = pirc_pkg::I_MIN_RST;
    logic signed [CFG_W-1:0]   imax_cfg = pirc_pkg::I_MAX_RST;
    logic                      negate_cfg = pirc_pkg::INCR_RST;
    logic signed [INTEG_W-1:0] integral_track = '0;

    loop_result_t awaited_results[$];
    loop_result_t expected;
    bit no_idle = 1'b0;
    int rx_wait = 0;
    int failures = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int settings_written = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{0, pirc_pkg::REG_SETPOINT, 0, 0, 0, 1, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 100, 10, 1, '{100, 1000, -101}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 32767, 65535, 1, '{32767, 100000, -32867}},
        '{0, pirc_pkg::REG_SETPOINT, 0, -32768, 65535, 1, '{-32768, -100000, 32868}},
        '{0, pirc_pkg::REG_SETPOINT, 0, -1, 1, 1, '{-1, -100000, 101}},
        '{1, pirc_pkg::REG_P_GAIN, 32'hFFFF8000, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_SETPOINT, 32'h00007FFF, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_INCR, 32'h00000000, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, -32768, 65535, 1, '{-65535, -100000, 8388380}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 32767, 0, 1, '{0, -100000, -100}},
        '{1, pirc_pkg::REG_P_GAIN, 32'h00007FFF, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_SETPOINT, 32'hFFFF8000, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_INCR, 32'h00000001, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 32767, 65535, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_I_MIN, 32'h00000032, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_I_MAX, 32'hFFFFFFCE, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, -5, 3, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_ISP, 32'h00000000, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 1234, 77, 0, '{0, 0, 0}},
        '{1, REG_SPARE_LO, 32'hFFFFFFFF, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 0, 65535, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_ISP, 32'hFFFFFFFF, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_I_MIN, 32'hFFFF8000, 0, 0, 0, '{0, 0, 0}},
        '{1, pirc_pkg::REG_I_MAX, 32'h00007FFF, 0, 0, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 32767, 65535, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, -32768, 65535, 0, '{0, 0, 0}},
        '{0, pirc_pkg::REG_SETPOINT, 0, 100, 1, 0, '{0, 0, 0}},
        '{1, REG_SPARE_HI, 32'h00000000, 0, 0, 0, '{0, 0, 0}}
    };

    pi_regulator_clamped_integral #(
        .MEAS_WIDTH(MEAS_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_measurement(s_measurement),
        .s_elapsed_ticks(s_elapsed_ticks),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_error_value(m_error_value),
        .m_integral_value(m_integral_value),
        .m_actuator_drive(m_actuator_drive),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic loop_result_t regulate(input logic signed [MEAS_W-1:0] meas,
                                              input logic [TICK_W-1:0] ticks);
        longint err, sum, lo, hi, per_unit, drive;
        loop_result_t r;
        per_unit = longint'(isp_cfg);
        err = longint'(meas) - longint'(setpoint_cfg);
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < -ERR_MAX - 1) err = -ERR_MAX - 1;
        sum = longint'(integral_track) + longint'(ticks) * err;
        lo = longint'(imin_cfg) * per_unit;
        hi = longint'(imax_cfg) * per_unit;
        if (sum < lo) sum = lo;
        if (sum > hi) sum = hi;
        if (sum > INTEG_TOP) sum = INTEG_TOP;
        if (sum < INTEG_BOTTOM) sum = INTEG_BOTTOM;
        integral_track = INTEG_W'(sum);
        drive = (err * longint'(kp_cfg)) >>> PSHIFT;
        if (per_unit != 0) drive = drive + sum / per_unit;
        if (negate_cfg) drive = -drive;
        if (drive > longint'(pirc_pkg::DRIVE_MAX)) drive = longint'(pirc_pkg::DRIVE_MAX);
        if (drive < longint'(pirc_pkg::DRIVE_MIN)) drive = longint'(pirc_pkg::DRIVE_MIN);
        r.error_value = ERR_W'(err);
        r.integral = INTEG_W'(sum);
        r.drive = DRIVE_W'(drive);
        return r;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pirc_pkg::REG_SETPOINT: setpoint_cfg = val[CFG_W-1:0];
            pirc_pkg::REG_P_GAIN:   kp_cfg = val[CFG_W-1:0];
            pirc_pkg::REG_ISP:      isp_cfg = val[ISP_W-1:0];
            pirc_pkg::REG_I_MIN:    imin_cfg = val[CFG_W-1:0];
            pirc_pkg::REG_I_MAX:    imax_cfg = val[CFG_W-1:0];
            pirc_pkg::REG_INCR:     negate_cfg = val[0];
            default:                ;
        endcase
        settings_written++;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic signed [CFG_W-1:0] sp,
                                  input logic signed [CFG_W-1:0] kp,
                                  input logic [ISP_W-1:0] isp,
                                  input logic signed [CFG_W-1:0] lo,
                                  input logic signed [CFG_W-1:0] hi,
                                  input logic incr);
        write_reg(pirc_pkg::REG_SETPOINT, DATA_W'(sp));
        write_reg(pirc_pkg::REG_P_GAIN, DATA_W'(kp));
        write_reg(pirc_pkg::REG_ISP, isp);
        write_reg(pirc_pkg::REG_I_MIN, DATA_W'(lo));
        write_reg(pirc_pkg::REG_I_MAX, DATA_W'(hi));
        write_reg(pirc_pkg::REG_INCR, DATA_W'(incr));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_sample(input logic signed [MEAS_W-1:0] meas,
                                input logic [TICK_W-1:0] ticks,
                                input bit use_known, input loop_result_t known);
        int gap;
        loop_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_measurement <= meas;
        s_elapsed_ticks <= ticks;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = regulate(meas, ticks);
        awaited_results.push_back(use_known ? known : predicted);
        samples_sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result error %0d integral %0d drive %0d",
                         $time, m_error_value, m_integral_value, m_actuator_drive);
                failures++;
            end else begin
                expected = awaited_results.pop_front();
                if (m_error_value !== expected.error_value) begin
                    $display("%0t: error_value expected %0d, got %0d",
                             $time, expected.error_value, m_error_value);
                    failures++;
                end
                if (m_integral_value !== expected.integral) begin
                    $display("%0t: integral_value expected %0d, got %0d",
                             $time, expected.integral, m_integral_value);
                    failures++;
                end
                if (m_actuator_drive !== expected.drive) begin
                    $display("%0t: actuator_drive expected %0d, got %0d",
                             $time, expected.drive, m_actuator_drive);
                    failures++;
                end
            end
            results_checked++;
            rx_wait = no_idle ? 0 : $urandom_range(0, 19);
            m_ready <= (rx_wait == 0);
        end else if (m_valid === 1'b1 && !m_ready) begin
            if (rx_wait == 0) begin
                m_ready <= 1'b1;
            end else begin
                rx_wait--;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Run stopped at the cycle limit with %0d results outstanding.",
                 awaited_results.size());
        $display("pi_regulator_clamped_integral_tb failed");
        $finish;
    end

    initial begin
        int row, phase, n, level, lim_lo, lim_hi, held;
        logic signed [MEAS_W-1:0] meas;
        logic [TICK_W-1:0] ticks;
        logic [ISP_W-1:0] isp_pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < PLAN_ROWS; row++) begin
            if (plan[row].is_write) begin
                drain_results();
                write_reg(plan[row].reg_idx, plan[row].reg_val);
            end else begin
                offer_sample(plan[row].meas, plan[row].ticks, plan[row].typed, plan[row].known);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            no_idle = (phase % 3 == 2);
            case (phase)
                0: begin
                    apply_settings(-16'sd32767 - 16'sd1, -16'sd32767 - 16'sd1, 32'd1,
                                   -16'sd32767 - 16'sd1, 16'sd32767, 1'b0);
                end
                1: begin
                    apply_settings(16'sd32767, 16'sd32767, 32'hFFFFFFFF,
                                   -16'sd32767 - 16'sd1, 16'sd32767, 1'b1);
                end
                default: begin
                    isp_pick = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 4000);
                    lim_lo = int'($urandom_range(0, 2000)) - 1000;
                    lim_hi = lim_lo + int'($urandom_range(0, 2000));
                    if ($urandom_range(0, 4) == 0) begin
                        held = lim_lo;
                        lim_lo = lim_hi;
                        lim_hi = held;
                    end
                    apply_settings(CFG_W'($urandom), CFG_W'($urandom), isp_pick,
                                   CFG_W'(lim_lo), CFG_W'(lim_hi),
                                   1'($urandom_range(0, 1)));
                end
            endcase
            for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    meas = MEAS_W'($urandom);
                    ticks = TICK_W'($urandom);
                end else begin
                    level = int'(setpoint_cfg) + int'($urandom_range(0, 1023)) - 512;
                    if (level > 32767) level = 32767;
                    if (level < -32768) level = -32768;
                    meas = MEAS_W'(level);
                    ticks = TICK_W'($urandom_range(0, 63));
                end
                offer_sample(meas, ticks, 1'b0, '0);
            end
        end

        drain_results();
        $display("Sent %0d requests across %0d register writes: reset defaults, gain and limit",
                 samples_sent, settings_written);
        $display("extremes, crossed limits, a zero divisor, spare addresses; %0d results checked.",
                 results_checked);
        if (failures == 0) begin
            $display("pi_regulator_clamped_integral_tb passed");
        end else begin
            $display("pi_regulator_clamped_integral_tb failed");
        end
        $finish;
    end

endmodule
